### hw/rtl/uart_rm_pkg.sv
// Shared types and constants for the 16550-style UART register model.
// No dependencies; used by the top level and the port checker.
package uart_rm_pkg;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_POLL  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // Register offsets
    localparam logic [3:0] ADDR_DATA    = 4'd0;
    localparam logic [3:0] ADDR_IER     = 4'd1;
    localparam logic [3:0] ADDR_IIR_FCR = 4'd2;
    localparam logic [3:0] ADDR_LCR     = 4'd3;
    localparam logic [3:0] ADDR_MCR     = 4'd4;
    localparam logic [3:0] ADDR_LSR     = 4'd5;
    localparam logic [3:0] ADDR_MSR     = 4'd6;
    localparam logic [3:0] ADDR_SCR     = 4'd7;

    // IIR codes
    localparam logic [7:0] IIR_RX   = 8'h04;
    localparam logic [7:0] IIR_TX   = 8'h02;
    localparam logic [7:0] IIR_NONE = 8'h01;

    localparam logic [7:0] MCR_MASK   = 8'h3F;
    localparam logic [7:0] READ_IDLE  = 8'hFF;
    localparam int         LCR_DLAB   = 7;
    localparam int         IER_RX_BIT = 0;
    localparam int         IER_TX_BIT = 1;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

endpackage

### hw/rtl/uart_16550_register_model.sv
// Top level of the 16550-style UART register model.
// Depends on uart_rm_pkg.
//
// Usage:
//   Slave channel s_*: one word per bus access or host poll. s_tuser is the
//   item kind (read, write, poll; code 3 does nothing). s_tdata carries the
//   register offset, write byte, host ready flags and received character.
//   Master channel m_*: exactly one result word per input word, in order:
//   read byte, interrupt line, transmit strobe and byte, receive-taken flag.
//
// The register state updates at the accepting edge, and the result sits in
// the output register from the next cycle on.
// Throughput is one word per cycle while m_tready is high, set by the single
// output register; a new word is taken in the same cycle the result is taken.
//
// When the receiver stalls, the result holds in the output register and
// s_tready drops until m_tready returns. Reset clears every register
// (IIR reads "no interrupt"), empties the output register and raises
// s_tready. FCR writes are accepted but have no readable effect, and the
// modem status source is never raised, so neither has storage.
module uart_16550_register_model (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] reg_addr, [11:4] write_data, [12] rx_ready, [13] tx_ready,
    // [21:14] rx_char, [23:22] zero
    input  logic [uart_rm_pkg::IN_DATA_W-1:0] s_tdata,
    // [1:0] mode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data, [8] irq_line, [9] tx_valid, [17:10] tx_byte,
    // [18] rx_taken, [23:19] zero
    output logic [uart_rm_pkg::OUT_DATA_W-1:0] m_tdata
);

    // Input field unpacking
    logic [3:0] in_addr;
    logic [7:0] in_wdata;
    logic       in_rx;
    logic       in_tx;
    logic [7:0] in_rch;
    uart_rm_pkg::mode_t in_mode;

    assign in_addr  = s_tdata[3:0];
    assign in_wdata = s_tdata[11:4];
    assign in_rx    = s_tdata[12];
    assign in_tx    = s_tdata[13];
    assign in_rch   = s_tdata[21:14];
    assign in_mode  = uart_rm_pkg::mode_t'(s_tuser);

    // Register file
    logic [7:0] ier_reg,  ier_next;
    logic [7:0] lcr_reg,  lcr_next;
    logic [5:0] mcr_reg,  mcr_next;
    logic [7:0] scr_reg,  scr_next;
    logic [7:0] dll_reg,  dll_next;
    logic [7:0] dlm_reg,  dlm_next;
    // LSR: only data-ready (bit 0) and transmit-empty (bits 5 and 6) are live
    logic       lsr_dr_reg,   lsr_dr_next;
    logic       lsr_thre_reg, lsr_thre_next;
    // pending sources: bit 0 receive, bit 1 transmit
    logic [1:0] pend_reg, pend_next;

    // Output register
    logic                               out_valid_reg;
    logic [uart_rm_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic       accept;
    logic       dlab;
    logic [7:0] iir;
    logic [7:0] lsr_value;
    logic [7:0] rd;
    logic       txv;
    logic [7:0] txb;
    logic       taken;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign dlab     = lcr_reg[uart_rm_pkg::LCR_DLAB];

    // IIR follows the highest-priority pending source
    always_comb
    begin
        if (pend_reg[0])
        begin
            iir = uart_rm_pkg::IIR_RX;
        end
        else if (pend_reg[1])
        begin
            iir = uart_rm_pkg::IIR_TX;
        end
        else
        begin
            iir = uart_rm_pkg::IIR_NONE;
        end
    end

    // LSR as rebuilt from the host flags on a read
    assign lsr_value = {1'b0, in_tx, in_tx, 4'b0000, in_rx};

    always_comb
    begin
        ier_next      = ier_reg;
        lcr_next      = lcr_reg;
        mcr_next      = mcr_reg;
        scr_next      = scr_reg;
        dll_next      = dll_reg;
        dlm_next      = dlm_reg;
        lsr_dr_next   = lsr_dr_reg;
        lsr_thre_next = lsr_thre_reg;
        pend_next     = pend_reg;
        rd            = uart_rm_pkg::READ_IDLE;
        txv           = 1'b0;
        txb           = 8'h00;
        taken         = 1'b0;

        case (in_mode)
            uart_rm_pkg::MODE_READ:
            begin
                case (in_addr)
                    uart_rm_pkg::ADDR_DATA:
                    begin
                        if (dlab)
                        begin
                            rd = dll_reg;
                        end
                        else
                        begin
                            rd           = in_rch;
                            taken        = 1'b1;
                            pend_next[0] = 1'b0;
                        end
                    end
                    uart_rm_pkg::ADDR_IER:     rd = dlab ? dlm_reg : ier_reg;
                    uart_rm_pkg::ADDR_IIR_FCR: rd = iir;
                    uart_rm_pkg::ADDR_LCR:     rd = lcr_reg;
                    uart_rm_pkg::ADDR_MCR:     rd = {2'b00, mcr_reg};
                    uart_rm_pkg::ADDR_LSR:
                    begin
                        // low nibble clears after the read
                        rd            = lsr_value;
                        lsr_dr_next   = 1'b0;
                        lsr_thre_next = in_tx;
                    end
                    uart_rm_pkg::ADDR_MSR:     rd = 8'h00;
                    uart_rm_pkg::ADDR_SCR:     rd = scr_reg;
                    default:                   rd = uart_rm_pkg::READ_IDLE;
                endcase
            end
            uart_rm_pkg::MODE_WRITE:
            begin
                case (in_addr)
                    uart_rm_pkg::ADDR_DATA:
                    begin
                        if (dlab)
                        begin
                            dll_next = in_wdata;
                        end
                        else
                        begin
                            txv = 1'b1;
                            txb = in_wdata;
                            // clear then re-raise: ends up as the enable bit
                            pend_next[1] = ier_reg[uart_rm_pkg::IER_TX_BIT];
                        end
                    end
                    uart_rm_pkg::ADDR_IER:
                    begin
                        if (dlab)
                        begin
                            dlm_next = in_wdata;
                        end
                        else
                        begin
                            ier_next = in_wdata;
                        end
                    end
                    uart_rm_pkg::ADDR_LCR: lcr_next = in_wdata;
                    uart_rm_pkg::ADDR_MCR: mcr_next = in_wdata[5:0];
                    uart_rm_pkg::ADDR_SCR: scr_next = in_wdata;
                    default:               ;
                endcase
            end
            uart_rm_pkg::MODE_POLL:
            begin
                // rising line status bits raise enabled sources
                if (in_rx)
                begin
                    lsr_dr_next = 1'b1;
                    if (!lsr_dr_reg && ier_reg[uart_rm_pkg::IER_RX_BIT])
                    begin
                        pend_next[0] = 1'b1;
                    end
                end
                if (in_tx)
                begin
                    lsr_thre_next = 1'b1;
                    if (!lsr_thre_reg && ier_reg[uart_rm_pkg::IER_TX_BIT])
                    begin
                        pend_next[1] = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        out_data_next = {5'b00000, taken, txb, txv, |pend_next, rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ier_reg      <= 8'h00;
            lcr_reg      <= 8'h00;
            mcr_reg      <= 6'h00;
            scr_reg      <= 8'h00;
            dll_reg      <= 8'h00;
            dlm_reg      <= 8'h00;
            lsr_dr_reg   <= 1'b0;
            lsr_thre_reg <= 1'b0;
            pend_reg     <= 2'b00;
        end
        else if (accept)
        begin
            ier_reg      <= ier_next;
            lcr_reg      <= lcr_next;
            mcr_reg      <= mcr_next;
            scr_reg      <= scr_next;
            dll_reg      <= dll_next;
            dlm_reg      <= dlm_next;
            lsr_dr_reg   <= lsr_dr_next;
            lsr_thre_reg <= lsr_thre_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### hw/rtl/uart_rm_checker.sv
// Port-level checks for the UART register model, bound to the top level.
// Depends on uart_rm_pkg and uart_16550_register_model.
module uart_rm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [uart_rm_pkg::IN_DATA_W-1:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [uart_rm_pkg::OUT_DATA_W-1:0] m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // every accepted word shows a result in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted word produced no result");

    // transmit byte is zero without the strobe
    a_txbyte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[9] |-> m_tdata[17:10] == 8'h00)
        else $error("tx_byte set without tx_valid");

    // only a read of a mapped offset returns data or consumes the character
    a_taken: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser != uart_rm_pkg::MODE_READ || s_tdata[3])
        |=> !m_tdata[18] && m_tdata[7:0] == uart_rm_pkg::READ_IDLE)
        else $error("non-read or unmapped word returned read data");

    // a poll never sends a byte; its idle read byte is checked by a_taken
    a_poll: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == uart_rm_pkg::MODE_POLL |=> !m_tdata[9])
        else $error("poll produced a transmit strobe");

endmodule

bind uart_16550_register_model uart_rm_checker u_uart_rm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### test/tb.sv
`timescale 1ns / 1ps
// Testbench for uart_16550_register_model: directed and random register traffic.
// Depends on uart_rm_pkg and the top level; predicts every result word itself.
module tb;

    // Interrupt source bits held by the predictor. The modem source has no
    // bit: nothing can ever raise it, so an MSR read never changes state.
    localparam int SRC_RX_BIT = 0;
    localparam int SRC_TX_BIT = 1;

    // Fixed run limit, far above the slowest correct run:
    // ~1400 words, each with the longest sender gap and receiver stall: ~225 us.
    localparam int RUN_LIMIT_NS = 3_000_000;
    localparam int RANDOM_WORDS = 1350;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_line;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_taken;
    } uart_result_t;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [uart_rm_pkg::IN_DATA_W-1:0]  s_tdata;
    logic [1:0]                         s_tuser;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [uart_rm_pkg::OUT_DATA_W-1:0] m_tdata;

    // Shadow copy of the register file
    logic [7:0] ier_q;
    logic [7:0] lcr_q;
    logic [7:0] mcr_q;
    logic [7:0] lsr_q;
    logic [7:0] scr_q;
    logic [7:0] dll_q;
    logic [7:0] dlm_q;
    logic [1:0] pending_q;

    uart_result_t result_q[$];   // expected result words, oldest first
    uart_result_t want_r;
    uart_result_t got_r;
    int           fail_count;
    bit           no_idle;       // set for stretches of back-to-back traffic

    uart_16550_register_model dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: applies one bus access or poll to the shadow registers
    // and returns the result word it must produce.
    // ------------------------------------------------------------------
    function automatic uart_result_t predict_access(uart_rm_pkg::mode_t mode,
                                                    logic [3:0] addr,
                                                    logic [7:0] wdata, logic rx,
                                                    logic tx, logic [7:0] rch);
        uart_result_t r;
        logic [7:0]   old_lsr;
        logic [7:0]   rise;
        logic         dlab;
        r = '{read_data: uart_rm_pkg::READ_IDLE, irq_line: 1'b0, tx_valid: 1'b0,
              tx_byte: 8'h00, rx_taken: 1'b0};
        dlab = lcr_q[uart_rm_pkg::LCR_DLAB];
        case (mode)
            uart_rm_pkg::MODE_READ:
                case (addr)
                    uart_rm_pkg::ADDR_DATA:
                        if (dlab)
                            r.read_data = dll_q;
                        else
                        begin
                            // rx_char is returned even when rx_ready is low
                            pending_q[SRC_RX_BIT] = 1'b0;
                            r.read_data = rch;
                            r.rx_taken = 1'b1;
                        end
                    uart_rm_pkg::ADDR_IER:     r.read_data = dlab ? dlm_q : ier_q;
                    uart_rm_pkg::ADDR_IIR_FCR:
                        r.read_data = pending_q[SRC_RX_BIT] ? uart_rm_pkg::IIR_RX :
                                      pending_q[SRC_TX_BIT] ? uart_rm_pkg::IIR_TX :
                                      uart_rm_pkg::IIR_NONE;
                    uart_rm_pkg::ADDR_LCR:     r.read_data = lcr_q;
                    uart_rm_pkg::ADDR_MCR:     r.read_data = mcr_q;
                    uart_rm_pkg::ADDR_LSR:
                    begin
                        // rebuilt from the host flags, then low nibble cleared
                        lsr_q = {1'b0, tx, tx, 4'b0000, rx};
                        r.read_data = lsr_q;
                        lsr_q = lsr_q & 8'hF0;
                    end
                    uart_rm_pkg::ADDR_MSR:     r.read_data = 8'h00;
                    uart_rm_pkg::ADDR_SCR:     r.read_data = scr_q;
                    default:                   r.read_data = uart_rm_pkg::READ_IDLE;
                endcase
            uart_rm_pkg::MODE_WRITE:
                case (addr)
                    uart_rm_pkg::ADDR_DATA:
                        if (dlab)
                            dll_q = wdata;
                        else
                        begin
                            r.tx_valid = 1'b1;
                            r.tx_byte = wdata;
                            // cleared and raised again: pending iff enabled
                            pending_q[SRC_TX_BIT] = ier_q[uart_rm_pkg::IER_TX_BIT];
                        end
                    uart_rm_pkg::ADDR_IER:
                        if (dlab)
                            dlm_q = wdata;
                        else
                            ier_q = wdata;
                    uart_rm_pkg::ADDR_LCR: lcr_q = wdata;
                    uart_rm_pkg::ADDR_MCR: mcr_q = wdata & uart_rm_pkg::MCR_MASK;
                    uart_rm_pkg::ADDR_SCR: scr_q = wdata;
                    default: ;   // FCR has no readable effect; LSR, MSR, 8..15 ignore
                endcase
            uart_rm_pkg::MODE_POLL:
            begin
                old_lsr = lsr_q;
                if (rx)
                    lsr_q[0] = 1'b1;
                if (tx)
                    lsr_q[6:5] = 2'b11;
                rise = (old_lsr ^ lsr_q) & lsr_q;
                // a rising edge is dropped when its enable is clear
                if (rise[0] && ier_q[uart_rm_pkg::IER_RX_BIT])
                    pending_q[SRC_RX_BIT] = 1'b1;
                if (rise[5] && ier_q[uart_rm_pkg::IER_TX_BIT])
                    pending_q[SRC_TX_BIT] = 1'b1;
            end
            default: ;   // undefined kind: no state change
        endcase
        r.irq_line = |pending_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: optional gap, then hold the word until it is accepted.
    // The expected result is queued at the accepting edge.
    // ------------------------------------------------------------------
    task automatic send_word(uart_rm_pkg::mode_t mode, logic [3:0] addr,
                             logic [7:0] wdata, logic rx, logic tx, logic [7:0] rch);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, rch, tx, rx, wdata, addr};
        do
            @(posedge clk);
        while (!s_tready);
        result_q.push_back(predict_access(mode, addr, wdata, rx, tx, rch));
    endtask

    // Receiver: draws a stall before each result word
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            repeat (stall)
            begin
                m_tready <= 1'b0;
                @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    task automatic report_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Checker: every accepted result word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (result_q.size() == 0)
            begin
                $display("%0t ns: unexpected result word, expected none actual %h",
                         $time, m_tdata);
                fail_count++;
            end
            else
            begin
                want_r = result_q.pop_front();
                got_r  = '{read_data: m_tdata[7:0], irq_line: m_tdata[8],
                           tx_valid: m_tdata[9], tx_byte: m_tdata[17:10],
                           rx_taken: m_tdata[18]};
                report_field("read_data", want_r.read_data, got_r.read_data);
                report_field("irq_line", {7'd0, want_r.irq_line}, {7'd0, got_r.irq_line});
                report_field("tx_valid", {7'd0, want_r.tx_valid}, {7'd0, got_r.tx_valid});
                report_field("tx_byte", want_r.tx_byte, got_r.tx_byte);
                report_field("rx_taken", {7'd0, want_r.rx_taken}, {7'd0, got_r.rx_taken});
                report_field("pad", 8'h00, {3'd0, m_tdata[23:19]});
            end
        end
    end

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Values straight out of reset, unmapped offsets and the undefined kind
    task automatic test_reset_state();
        send_word(uart_rm_pkg::MODE_READ, uart_rm_pkg::ADDR_IIR_FCR, 8'h00, 1'b0, 1'b0, 8'h00);
        send_word(uart_rm_pkg::MODE_READ, uart_rm_pkg::ADDR_IER, 8'h00, 1'b0, 1'b0, 8'h00);
        send_word(uart_rm_pkg::MODE_READ, uart_rm_pkg::ADDR_LSR, 8'h00, 1'b1, 1'b0, 8'h00);
        send_word(uart_rm_pkg::MODE_READ, uart_rm_pkg::ADDR_MSR, 8'h00, 1'b1, 1'b1, 8'hFF);
        send_word(uart_rm_pkg::MODE_READ, 4'd15, 8'hFF, 1'b1, 1'b1, 8'hFF);
        send_word(uart_rm_pkg::MODE_NONE, uart_rm_pkg::ADDR_DATA, 8'hFF, 1'b1, 1'b1, 8'hFF);
    endtask

    // Divisor latches behind DLAB, masks, scratch, ignored writes
    task automatic test_register_file();
        send_word(uart_rm_pkg::MODE_WRITE, uart_rm_pkg::ADDR_LCR, 8'h80, 1'b0, 1'b0, 8'h00);
        send_word(uart_rm_pkg::MODE_WRITE, uart_rm_pkg::ADDR_DATA, 8'hFF, 1'b0, 1'b0, 8'h00);
        send_word(uart_rm_pkg::MODE_WRITE, uart_rm_pkg::ADDR_IER, 8'h00, 1'b0, 1'b0, 8'h00);
        send_word(uart_rm_pkg::MODE_READ, uart_rm_pkg::ADDR_DATA, 8'h00, 1'b1, 1'b0, 8'h5A);
        send_word(uart_rm_pkg::MODE_READ, uart_rm_pkg::ADDR_IER, 8'h00, 1'b0, 1'b0, 8'h00);
        send_word(uart_rm_pkg::MODE_WRITE, uart_rm_pkg::ADDR_LCR, 8'h7F, 1'b0, 1'b0, 8'h00);
        send_word(uart_rm_pkg::MODE_WRITE, uart_rm_pkg::ADDR_MCR, 8'hFF, 1'b0, 1'b0, 8'h00);
        send_word(uart_rm_pkg::MODE_WRITE, uart_rm_pkg::ADDR_IIR_FCR, 8'hFF, 1'b0, 1'b0,
                  8'h00);
        send_word(uart_rm_pkg::MODE_WRITE, uart_rm_pkg::ADDR_SCR, 8'hFF, 1'b0, 1'b0, 8'h00);
        send_word(uart_rm_pkg::MODE_WRITE, 4'd8, 8'h55, 1'b0, 1'b0, 8'h00);
        send_word(uart_rm_pkg::MODE_READ, uart_rm_pkg::ADDR_MCR, 8'h00, 1'b0, 1'b0, 8'h00);
        send_word(uart_rm_pkg::MODE_READ, uart_rm_pkg::ADDR_SCR, 8'h00, 1'b0, 1'b0, 8'h00);
        send_word(uart_rm_pkg::MODE_READ, uart_rm_pkg::ADDR_LCR, 8'h00, 1'b0, 1'b0, 8'h00);
    endtask

    // Source priority, clearing by data read and transmit, disabled edges
    task automatic test_interrupt_sources();
        send_word(uart_rm_pkg::MODE_WRITE, uart_rm_pkg::ADDR_IER, 8'h0B, 1'b0, 1'b0, 8'h00);
        send_word(uart_rm_pkg::MODE_POLL, uart_rm_pkg::ADDR_DATA, 8'h00, 1'b1, 1'b1, 8'h00);
        send_word(uart_rm_pkg::MODE_READ, uart_rm_pkg::ADDR_IIR_FCR, 8'h00, 1'b0, 1'b0, 8'h00);
        // data read with rx_ready low still returns the character
        send_word(uart_rm_pkg::MODE_READ, uart_rm_pkg::ADDR_DATA, 8'h00, 1'b0, 1'b0, 8'hC3);
        send_word(uart_rm_pkg::MODE_READ, uart_rm_pkg::ADDR_IIR_FCR, 8'h00, 1'b0, 1'b0, 8'h00);
        send_word(uart_rm_pkg::MODE_WRITE, uart_rm_pkg::ADDR_DATA, 8'h00, 1'b0, 1'b0, 8'h00);
        send_word(uart_rm_pkg::MODE_READ, uart_rm_pkg::ADDR_LSR, 8'h00, 1'b0, 1'b0, 8'h00);
        send_word(uart_rm_pkg::MODE_WRITE, uart_rm_pkg::ADDR_IER, 8'h00, 1'b0, 1'b0, 8'h00);
        // edges now disabled; the transmit source already pending stays
        send_word(uart_rm_pkg::MODE_POLL, uart_rm_pkg::ADDR_DATA, 8'h00, 1'b1, 1'b1, 8'h00);
        send_word(uart_rm_pkg::MODE_READ, uart_rm_pkg::ADDR_IIR_FCR, 8'h00, 1'b0, 1'b0, 8'h00);
        send_word(uart_rm_pkg::MODE_WRITE, uart_rm_pkg::ADDR_DATA, 8'hFF, 1'b0, 1'b0, 8'h00);
    endtask

    // Random traffic: mostly mapped offsets, polls mixed in so that the
    // line status bits keep rising and falling, a few unmapped and
    // undefined words, with back-to-back stretches now and then.
    task automatic test_random_traffic();
        int                 pick;
        uart_rm_pkg::mode_t mode;
        logic [3:0]         addr;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 150 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 35)
                mode = uart_rm_pkg::MODE_READ;
            else if (pick < 65)
                mode = uart_rm_pkg::MODE_WRITE;
            else if (pick < 97)
                mode = uart_rm_pkg::MODE_POLL;
            else
                mode = uart_rm_pkg::MODE_NONE;
            addr = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                               : 4'($urandom_range(0, 7));
            send_word(mode, addr, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        fail_count = 0;
        no_idle    = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= uart_rm_pkg::MODE_NONE;
        ier_q = 8'h00;
        lcr_q = 8'h00;
        mcr_q = 8'h00;
        lsr_q = 8'h00;
        scr_q = 8'h00;
        dll_q = 8'h00;
        dlm_q = 8'h00;
        pending_q = 2'b00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_register_file();
        test_interrupt_sources();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("PASS uart_16550_register_model");
        else
            $display("FAIL uart_16550_register_model");
        $finish;
    end

    // Watchdog
    initial
    begin
        #RUN_LIMIT_NS;
        $display("FAIL uart_16550_register_model");
        $finish;
    end

endmodule
